// ===== hw/rtl/fcfla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfla_pkg
// Shared types and constants for the fixed-cell free-list allocator.
// ----------------------------------------------------------------------------
package fcfla_pkg;

  localparam int POOL_SIZE  = 256;
  localparam int CELL_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int FRESH_W    = CELL_W + 1;
  localparam int IDX_W      = 8;
  localparam int STATUS_W   = 2;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // one word per cell: live flag, link valid flag, link to next free cell
  typedef struct packed {
    logic              live;
    logic              link_valid;
    logic [CELL_W-1:0] link;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hw/rtl/fcfla_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fixed_cell_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_cell_free_list_allocator
// Pool of equally sized cells kept on a linked free list in one RAM.
// Allocate pops the head cell, free pushes a live cell back on the head.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   req     | req_valid req_stall command     | in
//           | cell_index                      |
//   rsp     | rsp_valid rsp_stall status      | out
//           | granted_index                   |
//
// Each request reads its cell word from the RAM as it is accepted in S_IDLE,
// then updates it and writes it back in S_READ. The registered RAM read sets this.
// Cells at or above the fresh count were never touched; their RAM words are
// ignored and taken as free, so no clearing pass is needed after reset.
// A stalled response holds the block in its update cycle.
// ----------------------------------------------------------------------------
module fixed_cell_free_list_allocator
  import fcfla_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                command,
  input  logic [IDX_W-1:0]    cell_index,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [IDX_W-1:0]    granted_index
);

  state_t             state, state_next;
  logic               req_cmd;
  logic               req_in_range;
  logic [CELL_W-1:0]  req_cell;
  logic [CELL_W-1:0]  head, head_next;
  logic               head_valid, head_valid_next;
  logic [FRESH_W-1:0] fresh, fresh_next;

  logic               ram_we;
  logic [CELL_W-1:0]  ram_waddr;
  entry_t             ram_wdata;
  logic [CELL_W-1:0]  ram_raddr;
  entry_t             ram_rdata;

  logic               accept;
  logic               finish;
  logic               head_fresh;
  logic               idx_fresh;
  logic               pop_link_valid;
  logic [CELL_W-1:0]  pop_link;
  logic [CELL_W-1:0]  head_inc;
  status_t            res_status;
  logic [IDX_W-1:0]   res_granted;

  fcfla_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(POOL_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign accept   = req_valid && !req_stall;
  assign finish   = (state == S_READ) && !(rsp_valid && rsp_stall);
  assign head_inc = CELL_W'(32'(head) + 32'd1);

  assign head_fresh = {1'b0, head} >= fresh;
  assign idx_fresh  = {1'b0, req_cell} >= fresh;

  always_comb begin
    if (head_fresh) begin
      pop_link_valid = 32'(head) != (POOL_SIZE - 1);
      pop_link       = pop_link_valid ? head_inc : '0;
    end else begin
      pop_link_valid = ram_rdata.link_valid;
      pop_link       = ram_rdata.link;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    req_stall       = 1'b1;
    ram_raddr       = CELL_W'(cell_index);
    ram_we          = 1'b0;
    ram_waddr       = req_cell;
    ram_wdata       = '0;
    head_next       = head;
    head_valid_next = head_valid;
    fresh_next      = fresh;
    res_status      = ST_OK;
    res_granted     = '0;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        ram_raddr = (command == CMD_ALLOC) ? head : CELL_W'(cell_index);
        if (req_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        ram_raddr = req_cmd ? req_cell : head;
        if (req_cmd == CMD_ALLOC) begin
          if (!head_valid) begin
            res_status = ST_EMPTY;
          end else begin
            res_granted          = IDX_W'(head);
            ram_we               = finish;
            ram_waddr            = head;
            ram_wdata.live       = 1'b1;
            ram_wdata.link_valid = pop_link_valid;
            ram_wdata.link       = pop_link;
            head_next            = pop_link;
            head_valid_next      = pop_link_valid;
            if (head_fresh) begin
              fresh_next = FRESH_W'({1'b0, head}) + FRESH_W'(1);
            end
          end
        end else begin
          if (!req_in_range || idx_fresh || !ram_rdata.live) begin
            res_status = ST_NOT_LIVE;
          end else begin
            ram_we               = finish;
            ram_waddr            = req_cell;
            ram_wdata.live       = 1'b0;
            ram_wdata.link_valid = head_valid;
            ram_wdata.link       = head;
            head_next            = req_cell;
            head_valid_next      = 1'b1;
          end
        end
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd      <= command;
      req_cell     <= CELL_W'(cell_index);
      req_in_range <= 32'(cell_index) < POOL_SIZE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      head_valid <= 1'b1;
      fresh      <= '0;
    end else if (finish) begin
      head       <= head_next;
      head_valid <= head_valid_next;
      fresh      <= fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status        <= res_status;
      granted_index <= res_granted;
    end
  end

  a_rsp_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_READ)
    else $error("response raised without an update cycle");

  a_write_in_update: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_READ && !(rsp_valid && rsp_stall))
    else $error("RAM written outside a completing update");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fresh) <= POOL_SIZE)
    else $error("fresh count beyond pool size");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> req_stall)
    else $error("request accepted during update");

  a_grant_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> granted_index == '0)
    else $error("nonzero grant on failed request");

endmodule

// ===== test/tb_fixed_cell_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_cell_free_list_allocator
// Self-checking bench for the free-list cell allocator. A shadow copy of the
// free list and live bits predicts every response. Directed requests cover
// reset order, LIFO reuse and frees of cells that are not live. Random
// traffic fills the pool to empty and drains it under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_fixed_cell_free_list_allocator
  import fcfla_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    status_t           st;
    logic [IDX_W-1:0]  granted;
  } alloc_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic                command;
  logic [IDX_W-1:0]    cell_index;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    granted_index;

  // shadow free list
  logic [CELL_W-1:0]   pool_link    [POOL_SIZE];
  logic                pool_link_ok [POOL_SIZE];
  logic                cell_live    [POOL_SIZE];
  logic [CELL_W-1:0]   pool_head;
  logic                pool_head_ok;

  alloc_result_t       pending_q[$];
  int                  fail_count = 0;
  int                  idle_cycles = 0;
  int                  send_idle_pct = 0;
  int                  rsp_stall_pct = 0;

  fixed_cell_free_list_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .command       (command),
    .cell_index    (cell_index),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .granted_index (granted_index)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  task automatic reset_pool_model();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_link[i]    = CELL_W'(i + 1);
      pool_link_ok[i] = (i + 1 < POOL_SIZE);
      cell_live[i]    = 1'b0;
    end
    pool_head    = '0;
    pool_head_ok = 1'b1;
  endtask

  // update the shadow list for one accepted request, queue its response
  task automatic apply_to_pool(input cmd_t c, input logic [IDX_W-1:0] idx);
    alloc_result_t r;
    logic [CELL_W-1:0] slot;
    r.st      = ST_OK;
    r.granted = '0;
    if (c == CMD_ALLOC) begin
      if (!pool_head_ok) begin
        r.st = ST_EMPTY;
      end else begin
        slot            = pool_head;
        r.granted       = IDX_W'(slot);
        cell_live[slot] = 1'b1;
        pool_head_ok    = pool_link_ok[slot];
        pool_head       = pool_link[slot];
      end
    end else begin
      if (int'(idx) >= POOL_SIZE || !cell_live[idx]) begin
        r.st = ST_NOT_LIVE;
      end else begin
        slot               = CELL_W'(idx);
        cell_live[slot]    = 1'b0;
        pool_link[slot]    = pool_head;
        pool_link_ok[slot] = pool_head_ok;
        pool_head          = slot;
        pool_head_ok       = 1'b1;
      end
    end
    pending_q.push_back(r);
  endtask

  task automatic send_request(input cmd_t c, input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    command    <= c;
    cell_index <= idx;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_to_pool(c, idx);
  endtask

  task automatic send_alloc();
    send_request(CMD_ALLOC, IDX_W'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic bit pick_live_cell(output logic [IDX_W-1:0] idx);
    int start;
    int c;
    start = $urandom_range(POOL_SIZE - 1);
    for (int i = 0; i < POOL_SIZE; i++) begin
      c = (start + i) % POOL_SIZE;
      if (cell_live[c]) begin
        idx = IDX_W'(c);
        return 1'b1;
      end
    end
    idx = '0;
    return 1'b0;
  endfunction

  // response check and watchdog
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_fixed_cell_free_list_allocator: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_q.size() == 0) begin
          $error("unexpected response: status %0d granted_index %0d", status, granted_index);
          fail_count++;
        end else begin
          e = pending_q.pop_front();
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            fail_count++;
          end
          if (granted_index !== e.granted) begin
            $error("granted_index expected %0d actual %0d", e.granted, granted_index);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic test_reset_order();
    repeat (3) send_alloc();
  endtask

  task automatic test_lifo_reuse();
    send_request(CMD_FREE, 8'd1);
    send_alloc();
    send_request(CMD_FREE, 8'd2);
    send_request(CMD_FREE, 8'd0);
    send_alloc();
    send_alloc();
    send_alloc();
    send_alloc();
  endtask

  task automatic test_not_live_frees();
    send_request(CMD_FREE, 8'd1);
    send_request(CMD_FREE, 8'd1);
    send_request(CMD_FREE, 8'd255);
    send_request(CMD_FREE, 8'h55);
    send_request(CMD_FREE, 8'hAA);
    send_request(CMD_FREE, 8'd128);
    send_request(CMD_FREE, 8'd0);
    send_request(CMD_FREE, 8'd0);
    send_alloc();
  endtask

  // pop until the list runs dry, then hit the empty case
  task automatic test_fill_to_empty();
    logic [IDX_W-1:0] idx;
    while (pool_head_ok) send_alloc();
    repeat (3) send_alloc();
    if (pick_live_cell(idx)) send_request(CMD_FREE, idx);
    send_alloc();
    send_alloc();
  endtask

  task automatic test_mixed_traffic(input int count, input int alloc_pct);
    logic [IDX_W-1:0] idx;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < alloc_pct) begin
        send_alloc();
      end else if ($urandom_range(99) < 85 && pick_live_cell(idx)) begin
        send_request(CMD_FREE, idx);
      end else begin
        send_request(CMD_FREE, IDX_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    command    = CMD_ALLOC;
    cell_index = '0;
    reset_pool_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_order();
    test_lifo_reuse();
    test_not_live_frees();
    test_fill_to_empty();
    test_mixed_traffic(200, 35);
    wait_drained();

    send_idle_pct = 45;
    rsp_stall_pct = 0;
    test_mixed_traffic(200, 60);

    send_idle_pct = 0;
    rsp_stall_pct = 45;
    test_fill_to_empty();
    test_mixed_traffic(200, 45);

    send_idle_pct = 15;
    rsp_stall_pct = 15;
    test_mixed_traffic(200, 70);
    test_fill_to_empty();
    test_mixed_traffic(50, 30);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_q.size() != 0) begin
      $error("%0d responses never arrived", pending_q.size());
    end
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("tb_fixed_cell_free_list_allocator: PASS");
    end else begin
      $display("tb_fixed_cell_free_list_allocator: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fcfla_pkg.sv
hw/rtl/fcfla_ram.sv
hw/rtl/fixed_cell_free_list_allocator.sv
test/tb_fixed_cell_free_list_allocator.sv
